@@ rtl/hfe_tsu_pkg.sv @@
// Shared types and constants for the track stream unpacker.
// Holds opcode codes, status codes and the stream state struct; no dependencies.
`default_nettype none

package hfe_tsu_pkg;

    // Opcodes as they appear after bit reversal
    localparam logic [7:0] OPC_NOP        = 8'hF0;
    localparam logic [7:0] OPC_SETINDEX   = 8'hF1;
    localparam logic [7:0] OPC_SETBITRATE = 8'hF2;
    localparam logic [7:0] OPC_SKIPBITS   = 8'hF3;
    localparam logic [7:0] OPC_RAND       = 8'hF4;
    localparam logic [3:0] OPC_PREFIX     = 4'hF;

    // Skip counts below this limit take effect
    localparam logic [7:0] SKIP_LIMIT     = 8'd8;

    // Opcode waiting for its operand byte
    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_BITRATE,
        PEND_SKIP,
        PEND_RAND,
        PEND_INVALID
    } pend_op_t;

    // Result status
    typedef enum logic [1:0] {
        ST_BYTE_READY,
        ST_BAD_OPCODE,
        ST_END_IN_OPCODE
    } status_t;

    // Per-stream state carried from one request to the next
    typedef struct packed {
        pend_op_t    op;
        logic [2:0]  skip;
        logic [7:0]  accum;
        logic [2:0]  count;
    } stream_state_t;

    localparam stream_state_t STATE_CLEAR = '{
        op:    PEND_NONE,
        skip:  3'd0,
        accum: 8'd0,
        count: 3'd0
    };

endpackage

`default_nettype wire

@@ rtl/hfe_tsu_step.sv @@
// Combinational step of the unpacker: decodes one raw byte against the stream state.
// Produces the next state and at most one result. Depends on hfe_tsu_pkg.
`default_nettype none

module hfe_tsu_step (
    input  wire logic                        v3_mode,
    input  wire logic [7:0]                  raw_byte,
    input  wire logic                        stream_end,
    input  wire hfe_tsu_pkg::stream_state_t  state_cur,
    output hfe_tsu_pkg::stream_state_t       state_nxt,
    output logic                             res_valid,
    output logic [7:0]                       res_data,
    output hfe_tsu_pkg::status_t             res_status
);
    import hfe_tsu_pkg::*;

    logic [7:0] rev_byte;
    logic       have_data;
    logic [7:0] data_bits;
    pend_op_t   op_nxt;
    logic [2:0] skip_nxt;
    logic       bad_op;

    // Bit reversal
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rev_byte[3'(i)] = raw_byte[3'(7 - i)];
        end
    end

    // Opcode and operand handling
    always_comb
    begin
        have_data  = 1'b0;
        data_bits  = rev_byte;
        op_nxt     = state_cur.op;
        skip_nxt   = state_cur.skip;
        bad_op     = 1'b0;
        unique case (state_cur.op)
            PEND_NONE:
            begin
                if (v3_mode && rev_byte[7:4] == OPC_PREFIX)
                begin
                    unique case (rev_byte)
                        OPC_NOP, OPC_SETINDEX: op_nxt = PEND_NONE;
                        OPC_SETBITRATE:        op_nxt = PEND_BITRATE;
                        OPC_SKIPBITS:          op_nxt = PEND_SKIP;
                        OPC_RAND:              op_nxt = PEND_RAND;
                        default:               op_nxt = PEND_INVALID;
                    endcase
                end
                else
                begin
                    have_data = 1'b1;
                end
            end
            PEND_BITRATE:
            begin
                op_nxt = PEND_NONE;
            end
            PEND_SKIP:
            begin
                if (rev_byte < SKIP_LIMIT)
                begin
                    skip_nxt = rev_byte[2:0];
                end
                op_nxt = PEND_NONE;
            end
            PEND_RAND:
            begin
                data_bits = 8'd0;
                have_data = 1'b1;
                op_nxt    = PEND_NONE;
            end
            default:
            begin
                bad_op = 1'b1;
                op_nxt = PEND_NONE;
            end
        endcase
    end

    // Bit packing: skip leading bits, shift the rest in at the top
    logic [2:0] skip_left;
    logic [3:0] cnt;
    logic [7:0] acc;
    logic       emit;
    logic [7:0] emit_byte;

    always_comb
    begin
        skip_left = state_cur.skip;
        cnt       = {1'b0, state_cur.count};
        acc       = state_cur.accum;
        emit      = 1'b0;
        emit_byte = 8'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (skip_left != 3'd0)
            begin
                skip_left = skip_left - 3'd1;
            end
            else
            begin
                acc = {data_bits[3'(i)], acc[7:1]};
                cnt = cnt + 4'd1;
                if (cnt == 4'd8)
                begin
                    emit      = 1'b1;
                    emit_byte = acc;
                    acc       = 8'd0;
                    cnt       = 4'd0;
                end
            end
        end
    end

    // Merge, then end-of-stream handling
    always_comb
    begin
        res_valid       = bad_op;
        res_data        = 8'd0;
        res_status      = bad_op ? ST_BAD_OPCODE : ST_BYTE_READY;
        state_nxt.op    = op_nxt;
        state_nxt.skip  = skip_nxt;
        state_nxt.accum = state_cur.accum;
        state_nxt.count = state_cur.count;
        if (have_data)
        begin
            state_nxt.skip  = 3'd0;
            state_nxt.accum = acc;
            state_nxt.count = cnt[2:0];
            if (emit)
            begin
                res_valid  = 1'b1;
                res_data   = emit_byte;
                res_status = ST_BYTE_READY;
            end
        end
        if (stream_end)
        begin
            if (op_nxt != PEND_NONE && !res_valid)
            begin
                res_valid  = 1'b1;
                res_data   = 8'd0;
                res_status = ST_END_IN_OPCODE;
            end
            state_nxt = STATE_CLEAR;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hfe_tsu_core.sv @@
// Top level of the track stream unpacker: input register, step logic, result register.
// Depends on hfe_tsu_pkg and hfe_tsu_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------
//  in      | input     | in_valid/in_stall  | raw_byte, stream_end
//  out     | output    | out_valid/out_stall| data_byte, status
//  cfg     | input     | cfg_write          | cfg_data (v3_mode)
//
// One request per cycle unless a held result stalls the input; a request's result is
// loaded into the result register when the request leaves the input register.
// Stream state advances when a request leaves the input register.
// rst_n clears the state, the mode bit and both valid flags at once.
// A held result stalls only requests that produce a result; others pass.
`default_nettype none

module hfe_track_stream_unpacker_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            raw_byte,
    input  wire logic                  stream_end,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 data_byte,
    output hfe_tsu_pkg::status_t       status
);
    import hfe_tsu_pkg::*;

    logic          v3_mode_reg;
    logic          in_valid_reg;
    logic [7:0]    raw_reg;
    logic          end_reg;
    stream_state_t state_reg;
    logic          out_valid_reg;
    logic [7:0]    data_reg;
    status_t       status_reg;

    stream_state_t state_next;
    logic          res_valid;
    logic [7:0]    res_data;
    status_t       res_status;
    logic          advance;
    logic          accept;

    hfe_tsu_step u_step (
        .v3_mode    (v3_mode_reg),
        .raw_byte   (raw_reg),
        .stream_end (end_reg),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_status (res_status)
    );

    // Flow control
    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            v3_mode_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_byte;
            end_reg <= stream_end;
        end
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            data_reg   <= res_data;
            status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
